/* rtl/bws_pkg.sv */
// Shared widths, constants and types for the bilinear warp sampler.
// No dependencies; the files that use it refer to it by scoped names.
package bws_pkg;

    localparam int R_W      = 16;   // Q0.16 random fractions and coordinates
    localparam int W_W      = 24;   // corner weights
    localparam int D_W      = 19;   // Q3.16 density
    localparam int NORM_W   = 20;   // end values are brought below 2^20
    localparam int VA_W     = 25;   // marginal end values, sum of two weights
    localparam int UA_W     = 40;   // conditional end values at scale 65536
    localparam int SQ_W     = 56;   // radicand of one linear draw
    localparam int PROD_W   = 41;   // 17 x 24 bit product
    localparam int BSUM_W   = 58;   // bilinear sum before normalisation
    localparam int WSUM_W   = 26;   // sum of the four weights
    localparam int DIVQ_W   = 18;   // quotient bits of one linear draw
    localparam int DENS_SHIFT = 14;

    localparam logic [R_W:0]   ONE_Q16   = 17'h10000;
    localparam logic [R_W-1:0] COORD_MAX = 16'hFFFF;

    typedef struct packed {
        logic [W_W-1:0] w00;
        logic [W_W-1:0] w10;
        logic [W_W-1:0] w01;
        logic [W_W-1:0] w11;
    } weights_t;

endpackage

/* rtl/bilinear_warp_sampler.sv */
// Top level of the bilinear warp sampler: v draw, conditional end values,
// u draw, density and the output register with its skid stage. Uses bws_pkg, bws_draw and bws_dens.
//
//  channel | signals                                               | dir | handshake
//  --------+-------------------------------------------------------+-----+-----------
//  input   | rand_u rand_v weight_00 weight_10 weight_01 weight_11 | in  | in_valid / in_stall
//  output  | coord_u coord_v density                               | out | out_valid / out_stall
//
// One request enters per cycle while in_stall is low; the path holds the
// two 28-stage square roots and the 18- and 19-stage dividers.
// Reset clears only the valid bits; the pipeline is empty afterwards.
// The whole pipeline advances together while the skid stage is empty; in_stall
// is the skid stage's full flag, so a stalled output costs no lost request.
module bilinear_warp_sampler (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [bws_pkg::R_W-1:0] rand_u,
    input  logic [bws_pkg::R_W-1:0] rand_v,
    input  logic [bws_pkg::W_W-1:0] weight_00,
    input  logic [bws_pkg::W_W-1:0] weight_10,
    input  logic [bws_pkg::W_W-1:0] weight_01,
    input  logic [bws_pkg::W_W-1:0] weight_11,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [bws_pkg::R_W-1:0] coord_u,
    output logic [bws_pkg::R_W-1:0] coord_v,
    output logic [bws_pkg::D_W-1:0] density
);
    localparam int RW  = bws_pkg::R_W;
    localparam int QW  = RW + 1;
    localparam int DW  = bws_pkg::D_W;
    localparam int VAW = bws_pkg::VA_W;
    localparam int UAW = bws_pkg::UA_W;
    localparam int PW  = bws_pkg::PROD_W;
    localparam int SW  = RW + $bits(bws_pkg::weights_t);

    logic en;

    bws_pkg::weights_t w_in;

    logic              vd_valid;
    logic [RW-1:0]     vd_cv;
    logic [SW-1:0]     vd_side;
    logic [RW-1:0]     vd_ru;
    bws_pkg::weights_t vd_w;

    logic [QW-1:0]     iv_next;
    logic              pv1_reg, pv2_reg;
    logic [RW-1:0]     ru1_reg, cv1_reg, ru2_reg, cv2_reg;
    bws_pkg::weights_t w1_reg, w2_reg;
    logic [PW-1:0]     pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic [UAW-1:0]    ua2_reg, ub2_reg;

    logic              ud_valid;
    logic [RW-1:0]     ud_cu;
    logic [SW-1:0]     ud_side;
    logic [RW-1:0]     ud_cv;
    bws_pkg::weights_t ud_w;

    logic          p_valid;
    logic [RW-1:0] p_cu, p_cv;
    logic [DW-1:0] p_dens;

    logic          out_valid_reg, skid_valid_reg;
    logic [RW-1:0] out_cu_reg, out_cv_reg, skid_cu_reg, skid_cv_reg;
    logic [DW-1:0] out_dens_reg, skid_dens_reg;
    logic          take;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    assign w_in.w00 = weight_00;
    assign w_in.w10 = weight_10;
    assign w_in.w01 = weight_01;
    assign w_in.w11 = weight_11;

    // Marginal in v: end values are the row sums of the weights.
    bws_draw #(
        .AW (VAW),
        .SW (SW)
    ) u_draw_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .r         (rand_v),
        .a         (VAW'(weight_00) + VAW'(weight_10)),
        .b         (VAW'(weight_01) + VAW'(weight_11)),
        .side_in   ({rand_u, w_in}),
        .out_valid (vd_valid),
        .x         (vd_cv),
        .side_out  (vd_side)
    );

    assign {vd_ru, vd_w} = vd_side;
    assign iv_next = bws_pkg::ONE_Q16 - QW'(vd_cv);

    // Conditional end values at the drawn v, at a scale of 65536.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv1_reg <= 1'b0;
            pv2_reg <= 1'b0;
        end
        else if (en)
        begin
            pv1_reg <= vd_valid;
            pv2_reg <= pv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ru1_reg <= vd_ru;
            cv1_reg <= vd_cv;
            w1_reg  <= vd_w;
            pa0_reg <= PW'(iv_next) * PW'(vd_w.w00);
            pa1_reg <= PW'(vd_cv) * PW'(vd_w.w01);
            pb0_reg <= PW'(iv_next) * PW'(vd_w.w10);
            pb1_reg <= PW'(vd_cv) * PW'(vd_w.w11);

            ru2_reg <= ru1_reg;
            cv2_reg <= cv1_reg;
            w2_reg  <= w1_reg;
            ua2_reg <= UAW'(pa0_reg + pa1_reg);
            ub2_reg <= UAW'(pb0_reg + pb1_reg);
        end
    end

    bws_draw #(
        .AW (UAW),
        .SW (SW)
    ) u_draw_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv2_reg),
        .r         (ru2_reg),
        .a         (ua2_reg),
        .b         (ub2_reg),
        .side_in   ({cv2_reg, w2_reg}),
        .out_valid (ud_valid),
        .x         (ud_cu),
        .side_out  (ud_side)
    );

    assign {ud_cv, ud_w} = ud_side;

    bws_dens u_dens (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ud_valid),
        .cu        (ud_cu),
        .cv        (ud_cv),
        .w         (ud_w),
        .out_valid (p_valid),
        .coord_u   (p_cu),
        .coord_v   (p_cv),
        .density   (p_dens)
    );

    assign take = out_valid_reg && !out_stall;

    // While the skid stage holds a request the pipeline is frozen and the
    // skid stage drains into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
            out_valid_reg <= p_valid;
        else if (p_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_cu_reg   <= skid_cu_reg;
                out_cv_reg   <= skid_cv_reg;
                out_dens_reg <= skid_dens_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_cu_reg   <= p_cu;
            out_cv_reg   <= p_cv;
            out_dens_reg <= p_dens;
        end
        else
        begin
            skid_cu_reg   <= p_cu;
            skid_cv_reg   <= p_cv;
            skid_dens_reg <= p_dens;
        end
    end

    assign out_valid = out_valid_reg;
    assign coord_u   = out_cu_reg;
    assign coord_v   = out_cv_reg;
    assign density   = out_dens_reg;

endmodule

/* rtl/bws_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with a side payload.
// Depends on nothing but its parameters.
module bws_isqrt #(
    parameter int XW = 56,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [XW-1:0]   x,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [XW/2-1:0] root,
    output logic [SW-1:0]   side_out
);
    localparam int RW  = XW / 2;
    localparam int RMW = RW + 1;
    localparam int SHW = RW + 3;

    logic [RW-1:0]  v_reg;
    logic [XW-1:0]  x_reg    [RW];
    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [SW-1:0]  side_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic           vin;
        logic [XW-1:0]  xin;
        logic [RMW-1:0] rin;
        logic [RW-1:0]  qin;
        logic [SW-1:0]  sin;
        logic [SHW-1:0] sh;
        logic [SHW-1:0] trial;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;

        if (i == 0) begin : g_head
            assign vin = in_valid;
            assign xin = x;
            assign rin = '0;
            assign qin = '0;
            assign sin = side_in;
        end else begin : g_body
            assign vin = v_reg[i-1];
            assign xin = x_reg[i-1];
            assign rin = rem_reg[i-1];
            assign qin = root_reg[i-1];
            assign sin = side_reg[i-1];
        end

        always_comb
        begin
            sh    = {rin, xin[XW-1-2*i -: 2]};
            trial = {1'b0, qin, 2'b01};
            if (sh >= trial)
            begin
                rem_next  = RMW'(sh - trial);
                root_next = {qin[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RMW'(sh);
                root_next = {qin[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= xin;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= sin;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

/* rtl/bws_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// The numerator shifted right by QW must be below the denominator.
module bws_div #(
    parameter int NW = 45,
    parameter int DW = 29,
    parameter int QW = 18,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);
    localparam int SHW = DW + 1;

    logic [QW-1:0] v_reg;
    logic [QW-1:0] nl_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic           vin;
        logic [QW-1:0]  nin;
        logic [DW-1:0]  din;
        logic [DW-1:0]  rin;
        logic [QW-1:0]  qin;
        logic [SW-1:0]  sin;
        logic [SHW-1:0] sh;
        logic [DW-1:0]  rem_next;
        logic           bit_next;

        if (i == 0) begin : g_head
            assign vin = in_valid;
            assign nin = num[QW-1:0];
            assign din = den;
            assign rin = DW'(num[NW-1:QW]);
            assign qin = '0;
            assign sin = side_in;
        end else begin : g_body
            assign vin = v_reg[i-1];
            assign nin = nl_reg[i-1];
            assign din = den_reg[i-1];
            assign rin = rem_reg[i-1];
            assign qin = q_reg[i-1];
            assign sin = side_reg[i-1];
        end

        always_comb
        begin
            sh = {rin, nin[QW-1-i]};
            if (sh >= {1'b0, din})
            begin
                rem_next = DW'(sh - {1'b0, din});
                bit_next = 1'b1;
            end
            else
            begin
                rem_next = DW'(sh);
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nl_reg[i]   <= nin;
                den_reg[i]  <= din;
                rem_reg[i]  <= rem_next;
                q_reg[i]    <= {qin[QW-2:0], bit_next};
                side_reg[i] <= sin;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

/* rtl/bws_draw.sv */
// One linear inverse-CDF draw: normalise, form the radicand, square root, divide.
// Uses bws_pkg, bws_isqrt and bws_div. AW must exceed bws_pkg::NORM_W.
module bws_draw #(
    parameter int AW = bws_pkg::VA_W,
    parameter int SW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [bws_pkg::R_W-1:0] r,
    input  logic [AW-1:0]           a,
    input  logic [AW-1:0]           b,
    input  logic [SW-1:0]           side_in,
    output logic                    out_valid,
    output logic [bws_pkg::R_W-1:0] x,
    output logic [SW-1:0]           side_out
);
    localparam int RW   = bws_pkg::R_W;
    localparam int NB   = bws_pkg::NORM_W;
    localparam int KW   = $clog2(AW - NB + 1);
    localparam int QW   = RW + 1;
    localparam int SQW  = bws_pkg::SQ_W;
    localparam int RTW  = SQW / 2;
    localparam int AAW  = 2 * NB;
    localparam int PPW  = NB + QW;
    localparam int PSW  = PPW + NB + 1;
    localparam int ABW  = NB + 1;
    localparam int NPW  = RW + ABW;
    localparam int NUMW = NPW + 8;
    localparam int DENW = RTW + 1;
    localparam int XQW  = bws_pkg::DIVQ_W;

    typedef struct packed {
        logic zab;  // both end values zero
        logic zr;   // random fraction zero
    } flag_t;

    localparam int FW   = $bits(flag_t);
    localparam int SQSW = NB + NPW + RW + FW + SW;
    localparam int DVSW = RW + FW + 1 + SW;

    logic [5:0] v_reg;

    // stage 1
    logic [RW-1:0] r1_reg;
    logic [AW-1:0] a1_reg, b1_reg, m1_reg;
    flag_t         f1_reg;
    logic [SW-1:0] s1_reg;
    // stage 2
    logic [RW-1:0] r2_reg;
    logic [AW-1:0] a2_reg, b2_reg;
    logic [KW-1:0] k2_reg;
    logic [KW-1:0] k_next;
    flag_t         f2_reg;
    logic [SW-1:0] s2_reg;
    // stage 3
    logic [RW-1:0] r3_reg;
    logic [NB-1:0] an3_reg, bn3_reg;
    flag_t         f3_reg;
    logic [SW-1:0] s3_reg;
    // stage 4
    logic [RW-1:0]  r4_reg;
    logic [NB-1:0]  a4_reg;
    logic [AAW-1:0] aa4_reg, bb4_reg;
    logic [QW-1:0]  q4_reg;
    logic [NPW-1:0] n4_reg;
    flag_t          f4_reg;
    logic [SW-1:0]  s4_reg;
    // stage 5
    logic [RW-1:0]  r5_reg;
    logic [NB-1:0]  a5_reg;
    logic [NPW-1:0] n5_reg;
    logic [PPW-1:0] paah5_reg, paal5_reg, pbbh5_reg, pbbl5_reg;
    flag_t          f5_reg;
    logic [SW-1:0]  s5_reg;
    // stage 6
    logic [SQW-1:0]  sq6_reg;
    logic [SQSW-1:0] sqs6_reg;

    // square root
    logic            sq_valid;
    logic [RTW-1:0]  sq_root;
    logic [SQSW-1:0] sq_side;
    logic [NB-1:0]   sa;
    logic [NPW-1:0]  sn;
    logic [RW-1:0]   sr;
    flag_t           sf;
    logic [SW-1:0]   ss;

    // stage 7
    logic            v7_reg;
    logic [NUMW-1:0] num7_reg;
    logic [DENW-1:0] den7_reg;
    logic [DENW-1:0] den_next;
    logic [DVSW-1:0] dvs7_reg;

    // divider
    logic            dv_valid;
    logic [XQW-1:0]  dv_quot;
    logic [DVSW-1:0] dv_side;
    logic [RW-1:0]   dr;
    flag_t           df;
    logic            ddz;
    logic [SW-1:0]   ds;

    // stage 8
    logic          v8_reg;
    logic [RW-1:0] x8_reg;
    logic [RW-1:0] x_next;
    logic [SW-1:0] s8_reg;

    // Smallest shift that brings the larger end value below 2^NB.
    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < AW - NB; i++)
        begin
            if (m1_reg[NB + i])
                k_next = KW'(i + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg     <= r;
            a1_reg     <= a;
            b1_reg     <= b;
            m1_reg     <= (a > b) ? a : b;
            f1_reg.zab <= (a == '0) && (b == '0);
            f1_reg.zr  <= (r == '0);
            s1_reg     <= side_in;

            r2_reg <= r1_reg;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            k2_reg <= k_next;
            f2_reg <= f1_reg;
            s2_reg <= s1_reg;

            r3_reg  <= r2_reg;
            an3_reg <= NB'(a2_reg >> k2_reg);
            bn3_reg <= NB'(b2_reg >> k2_reg);
            f3_reg  <= f2_reg;
            s3_reg  <= s2_reg;

            r4_reg  <= r3_reg;
            a4_reg  <= an3_reg;
            aa4_reg <= AAW'(an3_reg) * AAW'(an3_reg);
            bb4_reg <= AAW'(bn3_reg) * AAW'(bn3_reg);
            q4_reg  <= bws_pkg::ONE_Q16 - QW'(r3_reg);
            n4_reg  <= NPW'(r3_reg) * NPW'(ABW'(an3_reg) + ABW'(bn3_reg));
            f4_reg  <= f3_reg;
            s4_reg  <= s3_reg;

            // The squares are split in halves to keep each product narrow.
            r5_reg    <= r4_reg;
            a5_reg    <= a4_reg;
            n5_reg    <= n4_reg;
            paah5_reg <= PPW'(aa4_reg[AAW-1:NB]) * PPW'(q4_reg);
            paal5_reg <= PPW'(aa4_reg[NB-1:0]) * PPW'(q4_reg);
            pbbh5_reg <= PPW'(bb4_reg[AAW-1:NB]) * PPW'(r4_reg);
            pbbl5_reg <= PPW'(bb4_reg[NB-1:0]) * PPW'(r4_reg);
            f5_reg    <= f4_reg;
            s5_reg    <= s4_reg;

            sq6_reg  <= SQW'((PSW'(paah5_reg) << NB) + PSW'(paal5_reg)
                           + (PSW'(pbbh5_reg) << NB) + PSW'(pbbl5_reg));
            sqs6_reg <= {a5_reg, n5_reg, r5_reg, f5_reg, s5_reg};
        end
    end

    bws_isqrt #(
        .XW (SQW),
        .SW (SQSW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[5]),
        .x         (sq6_reg),
        .side_in   (sqs6_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    assign {sa, sn, sr, sf, ss} = sq_side;
    assign den_next = DENW'({sa, 8'h00}) + DENW'(sq_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= sq_valid;
            v8_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num7_reg <= {sn, 8'h00};
            den7_reg <= den_next;
            dvs7_reg <= {sr, sf, den_next == '0, ss};
            x8_reg   <= x_next;
            s8_reg   <= ds;
        end
    end

    bws_div #(
        .NW (NUMW),
        .DW (DENW),
        .QW (XQW),
        .SW (DVSW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       (num7_reg),
        .den       (den7_reg),
        .side_in   (dvs7_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    assign {dr, df, ddz, ds} = dv_side;

    // Both end values zero passes the fraction through; a zero fraction or
    // a zero denominator gives zero; otherwise the quotient saturates.
    always_comb
    begin
        priority if (df.zab)
            x_next = dr;
        else if (df.zr || ddz)
            x_next = '0;
        else if (dv_quot > XQW'(bws_pkg::COORD_MAX))
            x_next = bws_pkg::COORD_MAX;
        else
            x_next = dv_quot[RW-1:0];
    end

    assign out_valid = v8_reg;
    assign x         = x8_reg;
    assign side_out  = s8_reg;

endmodule

/* rtl/bws_dens.sv */
// Bilinear density at the sampled point, normalised by the weight sum.
// Uses bws_pkg and bws_div.
module bws_dens (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [bws_pkg::R_W-1:0] cu,
    input  logic [bws_pkg::R_W-1:0] cv,
    input  bws_pkg::weights_t       w,
    output logic                    out_valid,
    output logic [bws_pkg::R_W-1:0] coord_u,
    output logic [bws_pkg::R_W-1:0] coord_v,
    output logic [bws_pkg::D_W-1:0] density
);
    localparam int RW   = bws_pkg::R_W;
    localparam int QW   = RW + 1;
    localparam int PW   = bws_pkg::PROD_W;
    localparam int TW   = bws_pkg::UA_W;
    localparam int HW   = TW / 2;
    localparam int HPW  = QW + HW;
    localparam int BW   = bws_pkg::BSUM_W;
    localparam int SUMW = bws_pkg::WSUM_W;
    localparam int DW   = bws_pkg::D_W;
    localparam int SH   = bws_pkg::DENS_SHIFT;
    localparam int NW   = BW - SH;
    localparam int DVSW = 2 * RW + 1;

    logic [3:0] v_reg;

    logic [QW-1:0]   iu_next, iv_next;
    logic [RW-1:0]   cu1_reg, cv1_reg;
    logic [QW-1:0]   iv1_reg;
    logic [PW-1:0]   p00_reg, p10_reg, p01_reg, p11_reg;
    logic [SUMW-1:0] ws1_reg;

    logic [RW-1:0]   cu2_reg, cv2_reg;
    logic [QW-1:0]   iv2_reg;
    logic [TW-1:0]   t0_reg, t1_reg;
    logic [SUMW-1:0] ws2_reg;

    logic [RW-1:0]   cu3_reg, cv3_reg;
    logic [HPW-1:0]  h0_reg, l0_reg, h1_reg, l1_reg;
    logic [SUMW-1:0] ws3_reg;

    logic [RW-1:0]   cu4_reg, cv4_reg;
    logic [BW-1:0]   bsum4_reg;
    logic [SUMW-1:0] ws4_reg;
    logic            zs4_reg;

    logic            dv_valid;
    logic [DW-1:0]   dv_quot;
    logic [DVSW-1:0] dv_side;
    logic [RW-1:0]   dcu, dcv;
    logic            dzs;

    logic          v5_reg;
    logic [RW-1:0] cu5_reg, cv5_reg;
    logic [DW-1:0] dens5_reg;

    assign iu_next = bws_pkg::ONE_Q16 - QW'(cu);
    assign iv_next = bws_pkg::ONE_Q16 - QW'(cv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[2:0], in_valid};
            v5_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cu1_reg <= cu;
            cv1_reg <= cv;
            iv1_reg <= iv_next;
            p00_reg <= PW'(iu_next) * PW'(w.w00);
            p10_reg <= PW'(cu) * PW'(w.w10);
            p01_reg <= PW'(iu_next) * PW'(w.w01);
            p11_reg <= PW'(cu) * PW'(w.w11);
            ws1_reg <= SUMW'(w.w00) + SUMW'(w.w10) + SUMW'(w.w01) + SUMW'(w.w11);

            // Blend along u first; each sum stays below 2^40.
            cu2_reg <= cu1_reg;
            cv2_reg <= cv1_reg;
            iv2_reg <= iv1_reg;
            t0_reg  <= TW'(p00_reg + p10_reg);
            t1_reg  <= TW'(p01_reg + p11_reg);
            ws2_reg <= ws1_reg;

            cu3_reg <= cu2_reg;
            cv3_reg <= cv2_reg;
            h0_reg  <= HPW'(iv2_reg) * HPW'(t0_reg[TW-1:HW]);
            l0_reg  <= HPW'(iv2_reg) * HPW'(t0_reg[HW-1:0]);
            h1_reg  <= HPW'(cv2_reg) * HPW'(t1_reg[TW-1:HW]);
            l1_reg  <= HPW'(cv2_reg) * HPW'(t1_reg[HW-1:0]);
            ws3_reg <= ws2_reg;

            cu4_reg   <= cu3_reg;
            cv4_reg   <= cv3_reg;
            bsum4_reg <= (BW'(h0_reg) << HW) + BW'(l0_reg)
                       + (BW'(h1_reg) << HW) + BW'(l1_reg);
            ws4_reg   <= ws3_reg;
            zs4_reg   <= (ws3_reg == '0);

            cu5_reg   <= dcu;
            cv5_reg   <= dcv;
            dens5_reg <= dzs ? DW'(bws_pkg::ONE_Q16) : dv_quot;
        end
    end

    // The fixed factor of 16384 is dropped from the numerator before dividing.
    bws_div #(
        .NW (NW),
        .DW (SUMW),
        .QW (DW),
        .SW (DVSW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[3]),
        .num       (bsum4_reg[BW-1:SH]),
        .den       (ws4_reg),
        .side_in   ({cu4_reg, cv4_reg, zs4_reg}),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    assign {dcu, dcv, dzs} = dv_side;

    assign out_valid = v5_reg;
    assign coord_u   = cu5_reg;
    assign coord_v   = cv5_reg;
    assign density   = dens5_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bilinear warp sampler.
// Depends on bws_pkg and bilinear_warp_sampler; predicts every sample in-line.
module testbench;

    typedef struct {
        logic [bws_pkg::R_W-1:0] coord_u;
        logic [bws_pkg::R_W-1:0] coord_v;
        logic [bws_pkg::D_W-1:0] density;
    } sample_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam longint unsigned Q16 = 64'd65536;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [bws_pkg::R_W-1:0] rand_u;
    logic [bws_pkg::R_W-1:0] rand_v;
    logic [bws_pkg::W_W-1:0] weight_00;
    logic [bws_pkg::W_W-1:0] weight_10;
    logic [bws_pkg::W_W-1:0] weight_01;
    logic [bws_pkg::W_W-1:0] weight_11;
    logic                    out_valid;
    logic                    out_stall;
    logic [bws_pkg::R_W-1:0] coord_u;
    logic [bws_pkg::R_W-1:0] coord_v;
    logic [bws_pkg::D_W-1:0] density;

    sample_t expected_samples[$];
    int      error_count;
    int      idle_cycles;
    int      stall_left;
    bit      no_gaps;

    bilinear_warp_sampler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rand_u    (rand_u),
        .rand_v    (rand_v),
        .weight_00 (weight_00),
        .weight_10 (weight_10),
        .weight_01 (weight_01),
        .weight_11 (weight_11),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .coord_u   (coord_u),
        .coord_v   (coord_v),
        .density   (density)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // One inverse-CDF draw of a linear density with end values a and b.
    function automatic longint unsigned inverse_linear(longint unsigned r,
                                                       longint unsigned a,
                                                       longint unsigned b);
        longint unsigned peak;
        longint unsigned radicand;
        longint unsigned denom;
        longint unsigned quot;
        int              shift;
        if (a == 0 && b == 0)
            return r;
        if (r == 0)
            return 0;
        peak = (a > b) ? a : b;
        shift = 0;
        while ((peak >> shift) >= (64'd1 << bws_pkg::NORM_W))
            shift++;
        a = a >> shift;
        b = b >> shift;
        radicand = (Q16 - r) * a * a + r * b * b;
        denom = (a << 8) + int_sqrt(radicand);
        if (denom == 0)
            return 0;
        quot = ((r * (a + b)) << 8) / denom;
        return (quot > bws_pkg::COORD_MAX) ? bws_pkg::COORD_MAX : quot;
    endfunction

    function automatic sample_t warp_sample(longint unsigned ru, longint unsigned rv,
                                            longint unsigned w00, longint unsigned w10,
                                            longint unsigned w01, longint unsigned w11);
        sample_t         s;
        longint unsigned cu, cv, iu, iv, total, bsum;
        cv = inverse_linear(rv, w00 + w10, w01 + w11);
        iv = Q16 - cv;
        cu = inverse_linear(ru, iv * w00 + cv * w01, iv * w10 + cv * w11);
        iu = Q16 - cu;
        total = w00 + w10 + w01 + w11;
        s.coord_u = cu[bws_pkg::R_W-1:0];
        s.coord_v = cv[bws_pkg::R_W-1:0];
        if (total == 0)
            s.density = bws_pkg::D_W'(Q16);
        else
        begin
            bsum = iu * iv * w00 + cu * iv * w10 + iu * cv * w01 + cu * cv * w11;
            s.density = bws_pkg::D_W'(bsum / ((64'd1 << bws_pkg::DENS_SHIFT) * total));
        end
        return s;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned want);
        $display("Mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
        error_count++;
    endtask

    // Sends one request after a random gap (none while no_gaps is set) and records its expected sample.
    task automatic send_request(logic [bws_pkg::R_W-1:0] ru, logic [bws_pkg::R_W-1:0] rv,
                                logic [bws_pkg::W_W-1:0] w00, logic [bws_pkg::W_W-1:0] w10,
                                logic [bws_pkg::W_W-1:0] w01, logic [bws_pkg::W_W-1:0] w11);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        rand_u    <= ru;
        rand_v    <= rv;
        weight_00 <= w00;
        weight_10 <= w10;
        weight_01 <= w01;
        weight_11 <= w11;
        do
            @(posedge clk);
        while (in_stall);
        expected_samples.push_back(warp_sample(ru, rv, w00, w10, w01, w11));
    endtask

    task automatic test_zero_weights();
        send_request(16'h0000, 16'h0000, '0, '0, '0, '0);
        send_request(16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
        send_request(16'h1234, 16'hABCD, '0, '0, '0, '0);
    endtask

    task automatic test_extreme_fractions();
        logic [bws_pkg::W_W-1:0] wmax;
        wmax = '1;
        send_request(16'h0000, 16'h0000, wmax, wmax, wmax, wmax);
        send_request(16'hFFFF, 16'hFFFF, wmax, wmax, wmax, wmax);
        send_request(16'hFFFF, 16'hFFFF, 24'd1, wmax, 24'd1, wmax);
        send_request(16'hFFFF, 16'hFFFF, '0, wmax, '0, wmax);
        send_request(16'hFFFF, 16'h0000, wmax, '0, wmax, '0);
        send_request(16'h0001, 16'h0001, 24'd1, 24'd1, 24'd1, 24'd1);
        send_request(16'h8000, 16'h8000, wmax, 24'd1, 24'd1, wmax);
        send_request(16'hFFFF, 16'hFFFF, '0, '0, '0, 24'd1);
    endtask

    task automatic test_degenerate_pairs();
        // A zero pair on one edge, and a zero conditional when v lands on it.
        send_request(16'h4321, 16'h5555, '0, '0, 24'h00FFFF, 24'hFFFFFF);
        send_request(16'h4321, 16'h0000, '0, '0, 24'h00FFFF, 24'hFFFFFF);
        send_request(16'h7777, 16'h3333, 24'h800000, 24'h000001, '0, '0);
        send_request(16'h9999, 16'hFFFF, '0, '0, '0, 24'h123456);
        send_request(16'hC000, 16'h4000, '0, 24'hFFFFFF, '0, '0);
        send_request(16'h2000, 16'hE000, 24'hFFFFFF, '0, 24'hFFFFFF, '0);
    endtask

    function automatic logic [bws_pkg::W_W-1:0] draw_weight(int style);
        case (style)
            0:       return bws_pkg::W_W'($urandom_range(0, 255));
            1:       return ($urandom_range(0, 3) == 0) ? '0 : bws_pkg::W_W'($urandom);
            2:       return bws_pkg::W_W'($urandom) | 24'hF00000;
            default: return bws_pkg::W_W'($urandom);
        endcase
    endfunction

    task automatic test_random_streams();
        int style;
        for (int n = 0; n < 700; n++)
        begin
            // Runs of back-to-back traffic with no idling on either side.
            if (n % 100 == 0)
                no_gaps = (n % 200 == 100);
            style = $urandom_range(0, 3);
            send_request(bws_pkg::R_W'($urandom), bws_pkg::R_W'($urandom),
                         draw_weight(style), draw_weight(style),
                         draw_weight(style), draw_weight(style));
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random stall after each sample unless no_gaps is set, and the check itself.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("Unexpected sample at %0t", $time);
                    error_count++;
                end
                else
                begin
                    sample_t want;
                    want = expected_samples.pop_front();
                    if (coord_u !== want.coord_u)
                        report_mismatch("coord_u", coord_u, want.coord_u);
                    if (coord_v !== want.coord_v)
                        report_mismatch("coord_v", coord_v, want.coord_v);
                    if (density !== want.density)
                        report_mismatch("density", density, want.density);
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 12);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rand_u      = '0;
        rand_v      = '0;
        weight_00   = '0;
        weight_10   = '0;
        weight_01   = '0;
        weight_11   = '0;
        out_stall   = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_weights();
        test_extreme_fractions();
        test_degenerate_pairs();
        test_random_streams();

        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/bws_pkg.sv
rtl/bws_isqrt.sv
rtl/bws_div.sv
rtl/bws_draw.sv
rtl/bws_dens.sv
rtl/bilinear_warp_sampler.sv
tb/testbench.sv
